>>> src/rbsp_pkg.sv
// Shared types and constants for the RGBA to 24-bit BMP stream packer.
`timescale 1ns / 1ps

package rbsp_pkg;

  localparam int unsigned DimW = 13;
  localparam int unsigned HdrBytes = 54;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       hdr;
    logic [1:0] pad;
    logic       eoi;
  } entry_t;

endpackage

>>> src/rbsp_front.sv
// Front end: accepts pixels, tracks row and column, and classifies each pixel.
`timescale 1ns / 1ps

module rbsp_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   red_i,
  input  logic [7:0]                   green_i,
  input  logic [7:0]                   blue_i,
  input  logic [rbsp_pkg::DimW-1:0]    width_i,
  input  logic [rbsp_pkg::DimW-1:0]    height_i,
  input  logic                         full_i,
  output logic                         push_o,
  output rbsp_pkg::entry_t             entry_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [16:0]   col_nx;
  logic [16:0]   row_nx;
  logic          row_end;
  logic          frame_end;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign col_nx    = 17'(col_q) + 17'd1;
  assign row_nx    = 17'(row_q) + 17'd1;
  assign row_end   = col_nx >= 17'(width_i);
  assign frame_end = row_end && (row_nx >= 17'(height_i));

  always_comb begin
    entry_o.blue  = blue_i;
    entry_o.green = green_i;
    entry_o.red   = red_i;
    entry_o.hdr   = (col_q == '0) && (row_q == '0);
    entry_o.pad   = row_end ? width_i[1:0] : 2'd0;
    entry_o.eoi   = frame_end;
    col_d = row_end ? '0 : col_nx[CW-1:0];
    row_d = row_q;
    if (row_end) begin
      row_d = frame_end ? '0 : row_nx[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> src/rbsp_queue.sv
// Two-entry queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module rbsp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rbsp_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output rbsp_pkg::entry_t head_o
);

  rbsp_pkg::entry_t mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o       = cnt_q == 2'd2;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> src/rbsp_back.sv
// Back end: turns each queued pixel into header, pixel and padding bytes.
`timescale 1ns / 1ps

module rbsp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  rbsp_pkg::entry_t          head_i,
  output logic                      pop_o,
  input  logic [rbsp_pkg::DimW-1:0] width_i,
  input  logic [rbsp_pkg::DimW-1:0] height_i,
  input  logic [31:0]               img_size_i,
  input  logic [31:0]               file_size_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      last_of_run_o,
  output logic                      end_of_image_o
);

  localparam logic [1:0] ST_NEW = 2'd0;
  localparam logic [1:0] ST_HDR = 2'd1;
  localparam logic [1:0] ST_PIX = 2'd2;
  localparam logic [1:0] ST_PAD = 2'd3;

  localparam logic [7:0]  MagicB    = 8'h42;
  localparam logic [7:0]  MagicM    = 8'h4D;
  localparam logic [7:0]  NumPlanes = 8'd1;
  localparam logic [7:0]  BitsPix   = 8'd24;
  localparam logic [31:0] InfoSize  = 32'd40;

  function automatic logic [7:0] hdr_byte(input logic [5:0]  idx,
                                          input logic [12:0] w,
                                          input logic [12:0] h,
                                          input logic [31:0] img,
                                          input logic [31:0] fsize);
    logic [31:0] word;
    logic [7:0]  b;
    logic [1:0]  sel;
    word = '0;
    b    = '0;
    sel  = idx[1:0] - 2'd2;
    case (idx) inside
      6'd0:          b = MagicB;
      6'd1:          b = MagicM;
      [6'd2:6'd5]:   word = fsize;
      [6'd10:6'd13]: word = 32'(rbsp_pkg::HdrBytes);
      [6'd14:6'd17]: word = InfoSize;
      [6'd18:6'd21]: word = 32'(w);
      [6'd22:6'd25]: word = 32'd0 - 32'(h);
      6'd26:         b = NumPlanes;
      6'd28:         b = BitsPix;
      [6'd34:6'd37]: word = img;
      default:       b = '0;
    endcase
    case (sel)
      2'd0:    b = b | word[7:0];
      2'd1:    b = b | word[15:8];
      2'd2:    b = b | word[23:16];
      default: b = b | word[31:24];
    endcase
    return b;
  endfunction

  logic [1:0] st_q, st_d, cur_st;
  logic [5:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       last_q, eoi_q;
  logic       advance, fire, last;

  assign advance = !out_valid_q || out_ready_i;
  assign fire    = head_valid_i && advance;
  assign pop_o   = fire && last;

  always_comb begin
    cur_st = st_q;
    if (st_q == ST_NEW) begin
      cur_st = head_i.hdr ? ST_HDR : ST_PIX;
    end
    st_d   = cur_st;
    idx_d  = idx_q;
    byte_d = '0;
    last   = 1'b0;
    unique case (cur_st)
      ST_HDR: begin
        byte_d = hdr_byte(idx_q, width_i, height_i, img_size_i, file_size_i);
        if (idx_q == 6'(rbsp_pkg::HdrBytes - 1)) begin
          st_d  = ST_PIX;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_PIX: begin
        case (idx_q[1:0])
          2'd0:    byte_d = head_i.blue;
          2'd1:    byte_d = head_i.green;
          default: byte_d = head_i.red;
        endcase
        if (idx_q == 6'd2) begin
          if (head_i.pad == 2'd0) begin
            last = 1'b1;
          end else begin
            st_d  = ST_PAD;
            idx_d = '0;
          end
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_PAD: begin
        if (idx_q[1:0] == head_i.pad - 2'd1) begin
          last = 1'b1;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      default: begin
        st_d = ST_NEW;
      end
    endcase
    if (last) begin
      st_d  = ST_NEW;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_NEW;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        st_q  <= st_d;
        idx_q <= idx_d;
      end
      if (advance) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      last_q <= last;
      eoi_q  <= last && head_i.eoi;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign last_of_run_o  = last_q;
  assign end_of_image_o = eoi_q;

  a_eoi_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_image_o) |-> last_of_run_o)
    else $error("end of image flagged on a byte that does not end its transaction");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("queue popped while empty");

  a_pad_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PAD) |-> (head_valid_i && head_i.pad != 2'd0))
    else $error("padding state without padding bytes to send");

  a_hdr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_HDR) |-> (head_valid_i && head_i.hdr &&
                          idx_q < 6'(rbsp_pkg::HdrBytes)))
    else $error("header index out of range or header without a first pixel");

  a_new_starts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_NEW) |-> (idx_q == 6'd0))
    else $error("byte index not cleared between transactions");

endmodule

>>> src/rgba_to_bmp24_stream_packer_top.sv
// Top level of the RGBA to 24-bit top-down BMP stream packer.
//
// Pixels enter in raster order on the input channel (in_valid_i/in_ready_o)
// and leave as BMP file bytes on the output channel (out_valid_o/out_ready_i),
// one byte per transaction. The first pixel of a frame is preceded by the
// 54-byte file header; each pixel gives blue, green and red bytes, and the
// last pixel of a row appends (width mod 4) zero bytes. last_of_run_o marks
// the final byte of each pixel and end_of_image_o the final byte of the file.
// Width and height are set through the APB port at addresses 0 and 4.
// The first byte of a pixel is registered in the queue, then in the output
// register, which sends one byte per cycle while out_ready_i is high. A pixel
// gives 3 bytes plus its padding, plus 54 header bytes on a frame's first
// pixel. A two-entry queue lets pixels be accepted while bytes still drain.
// Reset empties the queue, clears the row and column counters and sets both
// dimensions to 1. When the receiver stalls, the output byte is held and the
// queue fills, after which in_ready_o drops until bytes are taken again.
`timescale 1ns / 1ps

module rgba_to_bmp24_stream_packer_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        end_of_image_o
);

  localparam int unsigned DW = rbsp_pkg::DimW;

  logic [DW-1:0]    width_q, height_q;
  logic [DW-1:0]    width_eff, height_eff;
  logic [14:0]      row_bytes;
  logic [27:0]      img_prod;
  logic [31:0]      img_q, fsize_q;
  logic             cfg_wr;
  logic             push, full, pop, head_valid;
  rbsp_pkg::entry_t entry, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? 32'(height_q) : 32'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DW'(1);
      height_q <= DW'(1);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        height_q <= pwdata[DW-1:0];
      end else begin
        width_q <= pwdata[DW-1:0];
      end
    end
  end

  always_comb begin
    width_eff = width_q;
    if (width_q == '0) begin
      width_eff = DW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      width_eff = DW'(MAX_WIDTH);
    end
    height_eff = height_q;
    if (height_q == '0) begin
      height_eff = DW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      height_eff = DW'(MAX_HEIGHT);
    end
  end

  assign row_bytes = (15'(width_eff) + {1'b0, width_eff, 1'b0} + 15'd3) & 15'h7FFC;
  assign img_prod  = 28'(row_bytes) * 28'(height_eff);

  always_ff @(posedge clk_i) begin
    img_q   <= 32'(img_prod);
    fsize_q <= img_q + 32'(rbsp_pkg::HdrBytes);
  end

  rbsp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry)
  );

  rbsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  rbsp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .width_i        (width_eff),
    .height_i       (height_eff),
    .img_size_i     (img_q),
    .file_size_i    (fsize_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule

>>> tb/rgba_to_bmp24_stream_packer_tb_pkg.sv
// Register map shared by the BMP stream packer testbench and its checker.
`timescale 1ns / 1ps

package rbsp_tb_pkg;

  typedef enum logic [2:0] {
    RegImageWidth  = 3'd0,
    RegImageHeight = 3'd4
  } reg_addr_e;

endpackage

>>> tb/rgba_to_bmp24_stream_packer_checker.sv
// Checker that predicts the BMP byte stream of the packer and compares every output transaction.
`timescale 1ns / 1ps

module rgba_to_bmp24_stream_packer_checker #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_of_run_i,
  input  logic        end_of_image_i,
  output int          mismatches_o,
  output int          bytes_pending_o
);

  localparam logic [31:0] InfoHdrBytes = 32'd40;
  localparam logic [7:0]  BitsPerPixel = 8'd24;
  localparam logic [7:0]  PlaneCount   = 8'd1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eoi;
  } bmp_byte_t;

  bmp_byte_t                 bmp_bytes_due_q[$];
  logic [rbsp_pkg::DimW-1:0] width_reg;
  logic [rbsp_pkg::DimW-1:0] height_reg;
  int unsigned               column_pos;
  int unsigned               row_pos;
  int                        mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic flag_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned effective_dim(input logic [rbsp_pkg::DimW-1:0] raw,
                                                input int unsigned limit);
    if (raw == '0) return 1;
    if (32'(raw) > limit) return limit;
    return 32'(raw);
  endfunction

  function automatic void pack_pixel(input logic [7:0] red, input logic [7:0] green,
                                     input logic [7:0] blue);
    int unsigned w;
    int unsigned h;
    logic [31:0] row_bytes;
    logic [31:0] image_bytes;
    logic [31:0] file_bytes;
    logic [31:0] width_field;
    logic [31:0] height_field;
    logic [31:0] offset_field;
    logic [7:0]  hdr [rbsp_pkg::HdrBytes];
    logic [7:0]  run_q[$];
    bit          row_end;
    bit          frame_end;
    bmp_byte_t   entry;

    w = effective_dim(width_reg, MAX_WIDTH);
    h = effective_dim(height_reg, MAX_HEIGHT);
    if (column_pos == 0 && row_pos == 0) begin
      row_bytes    = (32'(w) * 32'd3 + 32'd3) & ~32'd3;
      image_bytes  = row_bytes * 32'(h);
      file_bytes   = image_bytes + 32'(rbsp_pkg::HdrBytes);
      width_field  = 32'(w);
      height_field = 32'd0 - 32'(h);
      offset_field = 32'(rbsp_pkg::HdrBytes);
      foreach (hdr[i]) hdr[i] = 8'h00;
      hdr[0]  = "B";
      hdr[1]  = "M";
      hdr[26] = PlaneCount;
      hdr[28] = BitsPerPixel;
      for (int k = 0; k < 4; k++) begin
        hdr[2 + k]  = file_bytes[8*k +: 8];
        hdr[10 + k] = offset_field[8*k +: 8];
        hdr[14 + k] = InfoHdrBytes[8*k +: 8];
        hdr[18 + k] = width_field[8*k +: 8];
        hdr[22 + k] = height_field[8*k +: 8];
        hdr[34 + k] = image_bytes[8*k +: 8];
      end
      foreach (hdr[i]) run_q = {run_q, hdr[i]};
    end

    run_q = {run_q, blue};
    run_q = {run_q, green};
    run_q = {run_q, red};

    row_end   = (column_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    if (row_end) begin
      repeat (w & 3) run_q = {run_q, 8'h00};
      column_pos = 0;
      row_pos    = frame_end ? 0 : row_pos + 1;
    end else begin
      column_pos++;
    end

    foreach (run_q[i]) begin
      entry.data = run_q[i];
      entry.last = (i == run_q.size() - 1);
      entry.eoi  = entry.last && frame_end;
      bmp_bytes_due_q = {bmp_bytes_due_q, entry};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bmp_byte_t due;
    if (!rst_ni) begin
      width_reg  = rbsp_pkg::DimW'(1);
      height_reg = rbsp_pkg::DimW'(1);
      column_pos = 0;
      row_pos    = 0;
      bmp_bytes_due_q.delete();
      bytes_pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (bmp_bytes_due_q.size() == 0) begin
          flag_mismatch($sformatf("byte %02h arrived with no transaction pending",
                                  out_byte_i));
        end else begin
          due = bmp_bytes_due_q.pop_front();
          if (out_byte_i !== due.data)
            flag_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_i, due.data));
          if (last_of_run_i !== due.last)
            flag_mismatch($sformatf("last_of_run %0b, expected %0b", last_of_run_i,
                                    due.last));
          if (end_of_image_i !== due.eoi)
            flag_mismatch($sformatf("end_of_image %0b, expected %0b", end_of_image_i,
                                    due.eoi));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          rbsp_tb_pkg::RegImageWidth: begin
            width_reg = pwdata[rbsp_pkg::DimW-1:0];
          end
          rbsp_tb_pkg::RegImageHeight: begin
            height_reg = pwdata[rbsp_pkg::DimW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) pack_pixel(red_i, green_i, blue_i);
      bytes_pending_o <= bmp_bytes_due_q.size();
    end
  end

endmodule

>>> tb/rgba_to_bmp24_stream_packer_top_tb.sv
// Testbench top that drives pixels and register writes into the BMP stream packer.
`timescale 1ns / 1ps

module rgba_to_bmp24_stream_packer_top_tb;

  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned ItemsPerPhase = 117;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  red_i       = '0;
  logic [7:0]  green_i     = '0;
  logic [7:0]  blue_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;
  logic        end_of_image_o;

  int          mismatch_count;
  int          bytes_pending;
  int unsigned cycle_count    = 0;
  int unsigned tx_gap_pct     = 29;
  int unsigned rx_stall_pct   = 60;

  always #5 clk_i = ~clk_i;

  rgba_to_bmp24_stream_packer_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_image_o (end_of_image_o)
  );

  rgba_to_bmp24_stream_packer_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_i      (out_byte_o),
    .last_of_run_i   (last_of_run_o),
    .end_of_image_i  (end_of_image_o),
    .mismatches_o    (mismatch_count),
    .bytes_pending_o (bytes_pending)
  );

  always @(posedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_gap_pct);
    end
    in_valid_i <= 1'b1;
    red_i      <= red;
    green_i    <= green;
    blue_i     <= blue;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random_pixels(input int unsigned count);
    repeat (count) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (bytes_pending != 0);
  endtask

  task automatic write_reg(input rbsp_tb_pkg::reg_addr_e addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [12:0] pick_dim(input int unsigned usual_max);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 13'($urandom_range(4097, 8191));
      2:       return 13'($urandom_range(9, 4096));
      default: return 13'($urandom_range(1, usual_max));
    endcase
  endfunction

  function automatic logic [31:0] reg_word(input logic [12:0] dim);
    logic [31:0] word;
    word = {19'd0, dim};
    if ($urandom_range(0, 3) == 0) word[31:13] = 19'($urandom);
    return word;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    logic [12:0] frame_w;
    logic [12:0] frame_h;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_for_drain();
    write_reg(rbsp_tb_pkg::RegImageWidth, 32'd0);
    write_reg(rbsp_tb_pkg::RegImageHeight, 32'd0);
    send_pixel(8'h5A, 8'hA5, 8'h3C);
    wait_for_drain();
    write_reg(rbsp_tb_pkg::RegImageWidth, 32'd3);
    write_reg(rbsp_tb_pkg::RegImageHeight, 32'd2);
    send_random_pixels(6);
    wait_for_drain();
    write_reg(rbsp_tb_pkg::RegImageWidth, {19'h7FFFF, 13'd4096});
    write_reg(rbsp_tb_pkg::RegImageHeight, {19'h7FFFF, 13'h1FFF});
    send_random_pixels(3);
    // Shrinking the frame part-way through must close the current row and frame.
    wait_for_drain();
    write_reg(rbsp_tb_pkg::RegImageWidth, 32'd2);
    write_reg(rbsp_tb_pkg::RegImageHeight, 32'd1);
    send_random_pixels(3);
    wait_for_drain();
    write_reg(rbsp_tb_pkg::RegImageWidth, 32'd4);
    send_random_pixels(4);

    frame_w = 13'd4;
    frame_h = 13'd1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_gap_pct   = 29;
          rx_stall_pct = 60;
        end
        1: begin
          tx_gap_pct   = 60;
          rx_stall_pct = 29;
        end
        default: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ItemsPerPhase) begin
        wait_for_drain();
        pick = $urandom_range(0, 3);
        if (pick != 1) begin
          frame_w = pick_dim(8);
          write_reg(rbsp_tb_pkg::RegImageWidth, reg_word(frame_w));
        end
        if (pick != 0) begin
          frame_h = pick_dim(4);
          write_reg(rbsp_tb_pkg::RegImageHeight, reg_word(frame_h));
        end
        if (frame_w >= 1 && frame_w <= 8 && frame_h >= 1 && frame_h <= 4 &&
            $urandom_range(0, 4) != 0)
          burst = frame_w * frame_h * $urandom_range(1, 2);
        else
          burst = $urandom_range(1, 10);
        send_random_pixels(burst);
        sent += burst;
      end
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
